// ===== rtl/dws_pkg.sv =====
package dws_pkg;

	localparam int DEPTH = 16;
	localparam int WORD_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int FUNC_W = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_FIELD_W = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 4'd0,
		FN_PUSH_BACK  = 4'd1,
		FN_POP_FRONT  = 4'd2,
		FN_POP_BACK   = 4'd3,
		FN_PEEK_FRONT = 4'd4,
		FN_PEEK_BACK  = 4'd5,
		FN_FIND       = 4'd6,
		FN_REMOVE     = 4'd7,
		FN_DUMP       = 4'd8
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SHIFT,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] item_word;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]        result_word;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic                     last;
	} rsp_t;

	// Ring position of an offset from the front; both operands are below DEPTH.
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/dws_ram.sv =====
module dws_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/deque_with_search.sv =====
// Bounded double-ended queue of words with masked search, held in a ring in one
// synchronous RAM. A request (func, item_word) is taken at a clock edge where
// start is high and busy is low. Results appear on rsp for one cycle each,
// marked by rsp_valid; the receiver must take them as they come.
// How each request is served, with n the number of entries held:
//   push, requests refused because the queue is empty or full, unused codes:
//   the result comes the cycle after the request and busy stays low, so one
//   request per cycle.
//   pop and peek: the RAM read is issued with the request, and S_READ
//   registers the word onto rsp. find: S_SCAN inspects entries from the front
//   up to the first match or the back entry. remove: the same scan, then
//   S_SHIFT moves each entry behind the match one place toward the front.
//   dump: n results in a row from S_DUMP, the final one with last set.
// Everything that walks the queue goes through the single RAM read port at one
// entry per cycle. The user must write the match mask via cfg_we/cfg_data only
// while the block is idle (not enforced). Reset empties the queue and sets the
// mask to all ones; the RAM is not cleared, as only held entries are ever read.
module deque_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dws_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data,
	output logic          rsp_valid,
	output dws_pkg::rsp_t rsp
);

	import dws_pkg::*;

	localparam int CMP_W = CNT_W + 1;

	state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [FUNC_W-1:0] func_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] mask_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	logic accept, empty, full, hit, scan_last, shift_more;
	logic [CMP_W-1:0] idx_plus1, idx_plus2;
	logic emit;
	logic [WORD_W-1:0] emit_word;
	status_t emit_status;
	logic emit_last;

	dws_ram #(
		.DEPTH(DEPTH),
		.WIDTH(WORD_W)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);
	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign idx_plus1 = CMP_W'(idx_q) + CMP_W'(1);
	assign idx_plus2 = CMP_W'(idx_q) + CMP_W'(2);
	// The entry at offset idx_q is the back entry.
	assign scan_last = (idx_plus1 == CMP_W'(count_q));
	assign shift_more = (idx_plus2 < CMP_W'(count_q));
	assign hit = (((rdata ^ key_q) & mask_q) == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.func)
						FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
							if (!empty) state_d = S_READ;
						end
						FN_FIND, FN_REMOVE: begin
							if (!empty) state_d = S_SCAN;
						end
						FN_DUMP: begin
							if (!empty) state_d = S_DUMP;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: state_d = S_IDLE;
			S_SCAN: begin
				if (hit) begin
					if (func_q == FN_REMOVE && !scan_last) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_IDLE;
					end
				end else if (scan_last) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (!shift_more) state_d = S_IDLE;
			end
			S_DUMP: begin
				if (scan_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		idx_d = idx_q;
		we = 1'b0;
		waddr = ring_add(front_q, idx_q);
		wdata = req.item_word;
		raddr = ring_add(front_q, idx_q);
		emit = 1'b0;
		emit_word = '0;
		emit_status = ST_OK;
		emit_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.func)
						FN_PUSH_FRONT: begin
							emit = 1'b1;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								front_d = (front_q == '0) ? IDX_W'(DEPTH - 1)
								                          : front_q - IDX_W'(1);
								we = 1'b1;
								waddr = front_d;
								count_d = count_q + CNT_W'(1);
							end
						end
						FN_PUSH_BACK: begin
							emit = 1'b1;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								we = 1'b1;
								waddr = ring_add(front_q, IDX_W'(count_q));
								count_d = count_q + CNT_W'(1);
							end
						end
						FN_POP_FRONT, FN_PEEK_FRONT: begin
							if (empty) begin
								emit = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								raddr = front_q;
								if (req.func == FN_POP_FRONT) begin
									front_d = ring_add(front_q, IDX_W'(1));
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						FN_POP_BACK, FN_PEEK_BACK: begin
							if (empty) begin
								emit = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								raddr = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));
								if (req.func == FN_POP_BACK) begin
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						FN_FIND, FN_REMOVE: begin
							if (empty) begin
								emit = 1'b1;
								emit_status = ST_NOT_FOUND;
							end else begin
								raddr = front_q;
								idx_d = '0;
							end
						end
						FN_DUMP: begin
							if (empty) begin
								emit = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								raddr = front_q;
								idx_d = '0;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_READ: begin
				emit = 1'b1;
				emit_word = rdata;
			end
			S_SCAN: begin
				if (hit) begin
					if (func_q == FN_FIND) begin
						emit = 1'b1;
						emit_word = rdata;
					end else if (scan_last) begin
						count_d = count_q - CNT_W'(1);
						emit = 1'b1;
					end else begin
						raddr = ring_add(front_q, IDX_W'(idx_plus1));
					end
				end else if (scan_last) begin
					emit = 1'b1;
					emit_status = ST_NOT_FOUND;
				end else begin
					idx_d = IDX_W'(idx_plus1);
					raddr = ring_add(front_q, IDX_W'(idx_plus1));
				end
			end
			S_SHIFT: begin
				// Move the entry behind the gap one place toward the front.
				we = 1'b1;
				waddr = ring_add(front_q, idx_q);
				wdata = rdata;
				if (shift_more) begin
					idx_d = IDX_W'(idx_plus1);
					raddr = ring_add(front_q, IDX_W'(idx_plus2));
				end else begin
					count_d = count_q - CNT_W'(1);
					emit = 1'b1;
				end
			end
			S_DUMP: begin
				emit = 1'b1;
				emit_word = rdata;
				emit_last = scan_last;
				if (!scan_last) begin
					idx_d = IDX_W'(idx_plus1);
					raddr = ring_add(front_q, IDX_W'(idx_plus1));
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			mask_q <= '1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			idx_q <= idx_d;
			rsp_valid_q <= emit;
			if (cfg_we) begin
				mask_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q <= req.item_word;
		end
		if (emit) begin
			rsp_q.result_word <= emit_word;
			rsp_q.status <= emit_status;
			rsp_q.entry_count <= COUNT_FIELD_W'(count_d);
			rsp_q.last <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import dws_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	// Room for the longest walk (a remove that scans and shifts the whole ring).
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        cfg_we;
	logic [31:0] cfg_data;
	logic        rsp_valid;
	rsp_t        rsp;

	// Shadow copy of the ring, its front position, the fill level and the mask.
	logic [WORD_W-1:0] ring_words [DEPTH];
	int                ring_front;
	int                ring_count;
	logic [31:0]       mask_shadow;

	rsp_t pending_rsps [$];
	int   fail_count;
	int   cycle_count;
	int   idle_pct;

	deque_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** deque_with_search: FAILED **");
			$finish;
		end
	end

	function automatic int slot(input int offset);
		return (ring_front + offset) % DEPTH;
	endfunction

	function automatic void queue_rsp(input logic [31:0] word, input status_t st, input bit fin);
		rsp_t r;
		r.result_word = word;
		r.status = st;
		r.entry_count = COUNT_FIELD_W'(ring_count);
		r.last = fin;
		pending_rsps.push_back(r);
	endfunction

	function automatic void predict_deque(input logic [3:0] fn, input logic [31:0] word);
		int at;
		at = -1;
		case (fn)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (ring_count == DEPTH) begin
					queue_rsp('0, ST_FULL, 1'b1);
				end else begin
					if (fn == FN_PUSH_FRONT) begin
						ring_front = (ring_front + DEPTH - 1) % DEPTH;
						ring_words[ring_front] = word;
					end else begin
						ring_words[slot(ring_count)] = word;
					end
					ring_count++;
					queue_rsp('0, ST_OK, 1'b1);
				end
			end
			FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
				if (ring_count == 0) begin
					queue_rsp('0, ST_EMPTY, 1'b1);
				end else if (fn == FN_POP_FRONT || fn == FN_PEEK_FRONT) begin
					at = ring_front;
					if (fn == FN_POP_FRONT) begin
						ring_front = (ring_front + 1) % DEPTH;
						ring_count--;
					end
					queue_rsp(ring_words[at], ST_OK, 1'b1);
				end else begin
					at = slot(ring_count - 1);
					if (fn == FN_POP_BACK)
						ring_count--;
					queue_rsp(ring_words[at], ST_OK, 1'b1);
				end
			end
			FN_FIND, FN_REMOVE: begin
				for (int i = 0; i < ring_count && at < 0; i++)
					if (((ring_words[slot(i)] ^ word) & mask_shadow) == '0)
						at = i;
				if (at < 0) begin
					queue_rsp('0, ST_NOT_FOUND, 1'b1);
				end else if (fn == FN_FIND) begin
					queue_rsp(ring_words[slot(at)], ST_OK, 1'b1);
				end else begin
					// Entries behind the match move one place toward the front.
					for (int i = at; i + 1 < ring_count; i++)
						ring_words[slot(i)] = ring_words[slot(i + 1)];
					ring_count--;
					queue_rsp('0, ST_OK, 1'b1);
				end
			end
			FN_DUMP: begin
				if (ring_count == 0)
					queue_rsp('0, ST_EMPTY, 1'b1);
				for (int i = 0; i < ring_count; i++)
					queue_rsp(ring_words[slot(i)], ST_OK, i + 1 == ring_count);
			end
			default: begin
				queue_rsp('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid) begin
			if (pending_rsps.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected: %h", $time, rsp);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.result_word !== want.result_word) begin
					fail_count++;
					$display("%0t: result_word expected %h got %h", $time,
						want.result_word, rsp.result_word);
				end
				if (rsp.status !== want.status) begin
					fail_count++;
					$display("%0t: status expected %0d got %0d", $time,
						want.status, rsp.status);
				end
				if (rsp.entry_count !== want.entry_count) begin
					fail_count++;
					$display("%0t: entry_count expected %0d got %0d", $time,
						want.entry_count, rsp.entry_count);
				end
				if (rsp.last !== want.last) begin
					fail_count++;
					$display("%0t: last expected %0b got %0b", $time,
						want.last, rsp.last);
				end
			end
		end
	end

	// Holds start until the item is taken, then maybe leaves a gap.
	task automatic send_item(input logic [3:0] fn, input logic [31:0] word);
		start <= 1'b1;
		req <= {fn, word};
		do @(posedge clk); while (busy);
		predict_deque(fn, word);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_match_mask(input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mask_shadow = value;
	endtask

	task automatic test_empty_queue;
		send_item(FN_POP_FRONT, 32'hFFFF_FFFF);
		send_item(FN_POP_BACK, 32'h0);
		send_item(FN_PEEK_FRONT, 32'h0);
		send_item(FN_PEEK_BACK, 32'h0);
		send_item(FN_FIND, 32'h0);
		send_item(FN_REMOVE, 32'hFFFF_FFFF);
		send_item(FN_DUMP, 32'h0);
		send_item(4'd9, 32'h0);
		send_item(4'd15, 32'hFFFF_FFFF);
	endtask

	task automatic test_end_access;
		send_item(FN_PUSH_FRONT, 32'h0);
		send_item(FN_PUSH_BACK, 32'hFFFF_FFFF);
		send_item(FN_PUSH_FRONT, 32'hA5A5_A5A5);
		send_item(FN_PEEK_FRONT, 32'h0);
		send_item(FN_PEEK_BACK, 32'h0);
		send_item(FN_FIND, 32'hFFFF_FFFF);
		// The middle entry goes, so the back one has to move up.
		send_item(FN_REMOVE, 32'h0);
		send_item(FN_DUMP, 32'h0);
		send_item(FN_POP_FRONT, 32'h0);
		send_item(FN_POP_BACK, 32'h0);
	endtask

	task automatic test_masked_search;
		drain();
		write_match_mask(32'h0000_FFFF);
		send_item(FN_PUSH_BACK, 32'h1234_ABCD);
		send_item(FN_FIND, 32'hFFFF_ABCD);
		send_item(FN_REMOVE, 32'h0000_ABCD);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [3:0]  fn;
		logic [31:0] word;
		int          roll;
		int          push_weight;
		bit          filling;
		filling = 1'b1;
		for (int k = 0; k < n_items; k++) begin
			if (ring_count == DEPTH)
				filling = 1'b0;
			else if (ring_count == 0)
				filling = 1'b1;
			else if ($urandom_range(29) == 0)
				filling = !filling;
			push_weight = filling ? 45 : 12;
			roll = $urandom_range(99);
			word = $urandom_range(1) ? $urandom : 32'($urandom_range(7));
			if (roll < push_weight)
				fn = $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
			else if (roll < push_weight + 10)
				fn = $urandom_range(1) ? FN_PEEK_FRONT : FN_PEEK_BACK;
			else if (roll < push_weight + 22)
				fn = FN_FIND;
			else if (roll < push_weight + 30)
				fn = FN_REMOVE;
			else if (roll < push_weight + 34)
				fn = FN_DUMP;
			else if (roll < push_weight + 36)
				fn = 4'($urandom_range(9, 15));
			else
				fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK;
			// Most keys are a held entry with only the ignored bits disturbed.
			if ((fn == FN_FIND || fn == FN_REMOVE) && ring_count != 0 && $urandom_range(3) != 0)
				word = ring_words[slot(int'($urandom_range(ring_count - 1)))]
					^ ($urandom & ~mask_shadow);
			send_item(fn, word);
		end
	endtask

	initial begin
		logic [31:0] masks [6];
		int          pcts [6];
		masks = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_0000, 32'h0000_000F, $urandom};
		pcts = '{24, 24, 71, 71, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		cycle_count = 0;
		fail_count = 0;
		ring_front = 0;
		ring_count = 0;
		mask_shadow = 32'hFFFF_FFFF;
		idle_pct = pcts[0];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_end_access();
		test_masked_search();
		for (int p = 0; p < 6; p++) begin
			drain();
			write_match_mask(masks[p]);
			idle_pct = pcts[p];
			test_random_traffic(67);
		end
		drain();

		if (fail_count == 0)
			$display("** deque_with_search: PASSED **");
		else
			$display("** deque_with_search: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dws_pkg.sv
rtl/dws_ram.sv
rtl/deque_with_search.sv
sim/tb.sv
